// File: src/ctw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctw_pkg: shared types and constants of the text console writer
// Word layouts, action codes and character constants used by every file.
// ----------------------------------------------------------------------------
package ctw_pkg;

    localparam int COLUMNS_DEFAULT = 80;
    localparam int ROWS_DEFAULT    = 25;
    localparam int CELL_W          = 16;

    localparam logic [1:0] ACT_PUT   = 2'd0;
    localparam logic [1:0] ACT_CLEAR = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    localparam logic [7:0] NEWLINE_CODE = 8'd10;
    localparam logic [7:0] SPACE_CODE   = 8'd32;
    localparam logic [7:0] RESET_COLOR  = 8'd15;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] char_code;
        logic [4:0] cell_row;
        logic [6:0] cell_col;
    } ctw_in_t;

    typedef struct packed {
        logic [6:0] cursor_col;
        logic [4:0] cursor_row;
        logic       scrolled;
        logic [7:0] cell_char;
        logic [7:0] cell_color;
    } ctw_out_t;

endpackage

// File: src/ctw_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctw_ram: frame store
// Simple dual-port memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module ctw_ram #(
    parameter int DEPTH  = ctw_pkg::COLUMNS_DEFAULT * ctw_pkg::ROWS_DEFAULT,
    parameter int ADDR_W = $clog2(DEPTH),
    parameter int DATA_W = ctw_pkg::CELL_W
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: src/ctw_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctw_seq: console sequencer
// Cursor state, item decode, the shared address unit and the sweep engine
// that clears, blanks and scrolls the frame store one cell per cycle.
// ----------------------------------------------------------------------------
module ctw_seq #(
    parameter int COLUMNS = ctw_pkg::COLUMNS_DEFAULT,
    parameter int ROWS    = ctw_pkg::ROWS_DEFAULT,
    parameter int ADDR_W  = $clog2(COLUMNS * ROWS)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  ctw_pkg::ctw_in_t      request,
    input  logic [7:0]            text_color,
    output logic                  done,
    output ctw_pkg::ctw_out_t     result,
    output logic                  wr_en,
    output logic [ADDR_W-1:0]     wr_addr,
    output logic [ctw_pkg::CELL_W-1:0] wr_data,
    output logic                  rd_en,
    output logic [ADDR_W-1:0]     rd_addr,
    input  logic [ctw_pkg::CELL_W-1:0] rd_data
);

    localparam int TOTAL    = COLUMNS * ROWS;
    localparam int COPY_LEN = (ROWS - 1) * COLUMNS;
    localparam int COL_W    = $clog2(COLUMNS + 1);
    localparam int ROW_W    = $clog2(ROWS);
    localparam int CNT_W    = $clog2(TOTAL + 1);

    localparam logic [COL_W-1:0]  COL_END  = COL_W'(COLUMNS);
    localparam logic [ROW_W-1:0]  ROW_LAST = ROW_W'(ROWS - 1);
    localparam logic [CNT_W-1:0]  CNT_END  = CNT_W'(TOTAL);
    localparam logic [CNT_W-1:0]  CNT_COPY = CNT_W'(COPY_LEN);
    localparam logic [ADDR_W-1:0] COLS_A   = ADDR_W'(COLUMNS);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_DISPATCH = 3'd1;
    localparam logic [2:0] ST_WRITE    = 3'd2;
    localparam logic [2:0] ST_SWEEP    = 3'd3;
    localparam logic [2:0] ST_READ     = 3'd4;
    localparam logic [2:0] ST_DONE     = 3'd5;

    localparam logic [1:0] MODE_INIT   = 2'd0;
    localparam logic [1:0] MODE_CLEAR  = 2'd1;
    localparam logic [1:0] MODE_SCROLL = 2'd2;

    logic [2:0]       state_reg, state_next;
    logic [1:0]       mode_reg, mode_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    ctw_pkg::ctw_in_t item_reg, item_next;
    logic             scrolled_reg, scrolled_next;
    logic [7:0]       cell_char_reg, cell_char_next;
    logic [7:0]       cell_color_reg, cell_color_next;

    logic [ROW_W-1:0]  unit_base;
    logic [ADDR_W-1:0] unit_off;
    logic [ADDR_W-1:0] unit_addr;
    logic              read_in_range;
    logic              is_newline;
    logic [ctw_pkg::CELL_W-1:0] blank_cell;

    // Shared address unit: base * COLUMNS + offset.
    assign unit_addr = ADDR_W'(ADDR_W'(unit_base) * COLS_A) + unit_off;

    assign read_in_range = (32'(item_reg.cell_row) < 32'(ROWS))
                         && (32'(item_reg.cell_col) < 32'(COLUMNS));
    assign is_newline    = (item_reg.char_code == ctw_pkg::NEWLINE_CODE);
    assign blank_cell    = {(mode_reg == MODE_INIT) ? ctw_pkg::RESET_COLOR : text_color,
                            ctw_pkg::SPACE_CODE};

    always_comb
    begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        cnt_next        = cnt_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        item_next       = item_reg;
        scrolled_next   = scrolled_reg;
        cell_char_next  = cell_char_reg;
        cell_color_next = cell_color_reg;
        unit_base       = row_reg;
        unit_off        = ADDR_W'(col_reg);
        wr_en           = 1'b0;
        wr_addr         = '0;
        wr_data         = '0;
        rd_en           = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    item_next       = request;
                    scrolled_next   = 1'b0;
                    cell_char_next  = '0;
                    cell_color_next = '0;
                    state_next      = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                unit_base = ROW_W'(item_reg.cell_row);
                unit_off  = ADDR_W'(item_reg.cell_col);
                case (item_reg.action)
                    ctw_pkg::ACT_PUT:
                    begin
                        if (is_newline || col_reg == COL_END)
                        begin
                            col_next = '0;
                            if (row_reg != ROW_LAST)
                            begin
                                row_next   = ROW_W'(row_reg + 1'b1);
                                state_next = is_newline ? ST_DONE : ST_WRITE;
                            end
                            else
                            begin
                                scrolled_next = 1'b1;
                                mode_next     = MODE_SCROLL;
                                cnt_next      = '0;
                                state_next    = ST_SWEEP;
                            end
                        end
                        else
                        begin
                            state_next = ST_WRITE;
                        end
                    end
                    ctw_pkg::ACT_CLEAR:
                    begin
                        mode_next  = MODE_CLEAR;
                        cnt_next   = '0;
                        state_next = ST_SWEEP;
                    end
                    ctw_pkg::ACT_READ:
                    begin
                        if (read_in_range)
                        begin
                            rd_en      = 1'b1;
                            state_next = ST_READ;
                        end
                        else
                        begin
                            state_next = ST_DONE;
                        end
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_WRITE:
            begin
                wr_en      = 1'b1;
                wr_addr    = unit_addr;
                wr_data    = {text_color, item_reg.char_code};
                col_next   = COL_W'(col_reg + 1'b1);
                state_next = ST_DONE;
            end
            ST_SWEEP:
            begin
                // Read one row ahead, write the cell behind the read pointer.
                unit_base = ROW_W'(1);
                unit_off  = ADDR_W'(cnt_reg);
                rd_en     = (mode_reg == MODE_SCROLL) && (cnt_reg < CNT_COPY);
                if (cnt_reg != '0)
                begin
                    wr_en   = 1'b1;
                    wr_addr = ADDR_W'(cnt_reg - 1'b1);
                    wr_data = ((mode_reg == MODE_SCROLL) && (cnt_reg <= CNT_COPY))
                            ? rd_data : blank_cell;
                end
                if (cnt_reg == CNT_END)
                begin
                    case (mode_reg)
                        MODE_INIT:   state_next = ST_IDLE;
                        MODE_SCROLL: state_next = is_newline ? ST_DONE : ST_WRITE;
                        default:     state_next = ST_DONE;
                    endcase
                end
                else
                begin
                    cnt_next = CNT_W'(cnt_reg + 1'b1);
                end
            end
            ST_READ:
            begin
                cell_char_next  = rd_data[7:0];
                cell_color_next = rd_data[15:8];
                state_next      = ST_DONE;
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign rd_addr = unit_addr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_SWEEP;
            mode_reg  <= MODE_INIT;
            cnt_reg   <= '0;
            col_reg   <= '0;
            row_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
            cnt_reg   <= cnt_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg       <= item_next;
        scrolled_reg   <= scrolled_next;
        cell_char_reg  <= cell_char_next;
        cell_color_reg <= cell_color_next;
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = (state_reg == ST_DONE);

    assign result.cursor_col = 7'(col_reg);
    assign result.cursor_row = 5'(row_reg);
    assign result.scrolled   = scrolled_reg;
    assign result.cell_char  = cell_char_reg;
    assign result.cell_color = cell_color_reg;

    a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (state_reg == ST_DISPATCH))
        else $error("accepted word did not reach dispatch");

    a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg == ST_WRITE || state_reg == ST_SWEEP))
        else $error("frame store written outside write or sweep");

    a_read_issued: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |-> $past(rd_en))
        else $error("cell captured without a read");

    a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(row_reg) < 32'(ROWS))
        else $error("cursor row out of range");

    a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(col_reg) <= 32'(COLUMNS))
        else $error("cursor column out of range");

endmodule

// File: src/text_console_writer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer_top: text console engine
// A ROWS by COLUMNS frame store of character and color cells with a cursor.
// ----------------------------------------------------------------------------
// A command word is taken when start is high and busy is low; busy stays
// high until its result has been shown. Every command gives one result word,
// shown for one cycle with done high; the receiver cannot hold it off.
// From dispatch to done, a command passes through these states:
//   newline without scroll, unused action codes, out-of-range reads: none
//   plain character: write; in-range read: read
//   clear screen: a sweep over all COLUMNS*ROWS cells
//   newline with scroll: sweep; character with scroll: sweep, then write
// The sweeps are set by the single write port of the frame store: one cell
// per cycle, reading one row ahead while scrolling. The next command may be
// started in the cycle after done. After reset the store is cleared to spaces
// in color 15 by a sweep over all COLUMNS*ROWS cells, with busy high; the
// cursor starts at row 0, column 0. The user must write the color register
// through cfg_valid and cfg_ready only while no command is in flight, which
// the block does not enforce; it then takes effect from the next command.
// ----------------------------------------------------------------------------
module text_console_writer_top #(
    parameter int COLUMNS = ctw_pkg::COLUMNS_DEFAULT,
    parameter int ROWS    = ctw_pkg::ROWS_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  ctw_pkg::ctw_in_t  request,
    output logic              done,
    output ctw_pkg::ctw_out_t result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [7:0]        cfg_data
);

    localparam int DEPTH  = COLUMNS * ROWS;
    localparam int ADDR_W = $clog2(DEPTH);

    logic [7:0]                  color_reg;
    logic                        wr_en;
    logic [ADDR_W-1:0]           wr_addr;
    logic [ctw_pkg::CELL_W-1:0]  wr_data;
    logic                        rd_en;
    logic [ADDR_W-1:0]           rd_addr;
    logic [ctw_pkg::CELL_W-1:0]  rd_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_reg <= ctw_pkg::RESET_COLOR;
        end
        else if (cfg_valid && cfg_ready)
        begin
            color_reg <= cfg_data;
        end
    end

    ctw_seq #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS),
        .ADDR_W  (ADDR_W)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .request    (request),
        .text_color (color_reg),
        .done       (done),
        .result     (result),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data)
    );

    ctw_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W),
        .DATA_W (ctw_pkg::CELL_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

endmodule

// File: verif/tb_text_console_writer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_text_console_writer_top: self-checking testbench of the text console writer
// Sends put, clear, read and unused command words under random sender gaps.
// A scoreboard keeps its own copy of the frame store, cursor and color. From
// these it predicts every result word and compares each one field by field.
// ----------------------------------------------------------------------------
import ctw_pkg::*;

class console_scoreboard;

    logic [15:0] screen [ROWS_DEFAULT][COLUMNS_DEFAULT];
    int          cur_col;
    int          cur_row;
    logic [7:0]  color;
    ctw_out_t    pending [$];
    int          fails;

    function void power_on();
        foreach (screen[r, c])
        begin
            screen[r][c] = {RESET_COLOR, SPACE_CODE};
        end
        cur_col = 0;
        cur_row = 0;
        color   = RESET_COLOR;
        fails   = 0;
    endfunction

    function void set_color(logic [7:0] value);
        color = value;
    endfunction

    function void blank_row(int row);
        for (int c = 0; c < COLUMNS_DEFAULT; c++)
        begin
            screen[row][c] = {color, SPACE_CODE};
        end
    endfunction

    function bit next_line();
        cur_col = 0;
        if (cur_row < ROWS_DEFAULT - 1)
        begin
            cur_row++;
            return 1'b0;
        end
        for (int r = 1; r < ROWS_DEFAULT; r++)
        begin
            for (int c = 0; c < COLUMNS_DEFAULT; c++)
            begin
                screen[r - 1][c] = screen[r][c];
            end
        end
        blank_row(ROWS_DEFAULT - 1);
        return 1'b1;
    endfunction

    function void note_command(ctw_in_t cmd);
        ctw_out_t word;
        word = '0;
        case (cmd.action)
            ACT_PUT:
            begin
                if (cmd.char_code == NEWLINE_CODE)
                begin
                    word.scrolled = next_line();
                end
                else
                begin
                    if (cur_col >= COLUMNS_DEFAULT)
                    begin
                        word.scrolled = next_line();
                    end
                    screen[cur_row][cur_col] = {color, cmd.char_code};
                    cur_col++;
                end
            end
            ACT_CLEAR:
            begin
                for (int r = 0; r < ROWS_DEFAULT; r++)
                begin
                    blank_row(r);
                end
            end
            ACT_READ:
            begin
                if (cmd.cell_row < ROWS_DEFAULT && cmd.cell_col < COLUMNS_DEFAULT)
                begin
                    {word.cell_color, word.cell_char} = screen[cmd.cell_row][cmd.cell_col];
                end
            end
            default:
            begin
            end
        endcase
        word.cursor_col = 7'(cur_col);
        word.cursor_row = 5'(cur_row);
        pending.push_back(word);
    endfunction

    task report(string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        fails++;
    endtask

    task check_result(ctw_out_t got);
        ctw_out_t want;
        if (pending.size() == 0)
        begin
            report($sformatf("result word %h with nothing expected", got));
            return;
        end
        want = pending.pop_front();
        if (got.cursor_col !== want.cursor_col)
        begin
            report($sformatf("cursor_col %0d, expected %0d", got.cursor_col, want.cursor_col));
        end
        if (got.cursor_row !== want.cursor_row)
        begin
            report($sformatf("cursor_row %0d, expected %0d", got.cursor_row, want.cursor_row));
        end
        if (got.scrolled !== want.scrolled)
        begin
            report($sformatf("scrolled %b, expected %b", got.scrolled, want.scrolled));
        end
        if (got.cell_char !== want.cell_char)
        begin
            report($sformatf("cell_char %h, expected %h", got.cell_char, want.cell_char));
        end
        if (got.cell_color !== want.cell_color)
        begin
            report($sformatf("cell_color %h, expected %h", got.cell_color, want.cell_color));
        end
    endtask

endclass

module tb_text_console_writer_top;

    localparam int         QUIET_LIMIT = 25000;
    localparam logic [1:0] ACT_UNUSED  = 2'd3;

    logic       clk;
    logic       rst_n     = 1'b0;
    logic       start     = 1'b0;
    ctw_in_t    request   = '0;
    logic       cfg_valid = 1'b0;
    logic [7:0] cfg_data  = '0;
    logic       busy;
    logic       done;
    logic       cfg_ready;
    ctw_out_t   result;

    console_scoreboard sb;
    int                quiet_cycles = 0;
    int                words_sent   = 0;

    text_console_writer_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            sb.check_result(result);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || (cfg_valid && cfg_ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("tb_text_console_writer_top failed");
                $finish;
            end
        end
    end

    function ctw_in_t make_word(logic [1:0] act, logic [7:0] code, logic [4:0] row,
                                logic [6:0] col);
        ctw_in_t cmd;
        cmd.action    = act;
        cmd.char_code = code;
        cmd.cell_row  = row;
        cmd.cell_col  = col;
        return cmd;
    endfunction

    task send_word(ctw_in_t cmd, int idle_pct);
        if ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < idle_pct);
        end
        start   <= 1'b1;
        request <= cmd;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        sb.note_command(cmd);
        words_sent++;
    endtask

    task drain();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task write_color(logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        sb.set_color(value);
    endtask

    task random_phase(int count, int idle_pct);
        ctw_in_t cmd;
        int      pick;
        int      len;
        int      row;
        int      stop;
        stop = words_sent + count;
        while (words_sent < stop)
        begin
            pick = $urandom_range(0, 99);
            cmd  = make_word(2'($urandom), 8'($urandom), 5'($urandom), 7'($urandom));
            if (pick < 40)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(75, 85)
                                                  : $urandom_range(0, 12);
                repeat (len)
                begin
                    cmd = make_word(ACT_PUT, 8'($urandom), 5'($urandom), 7'($urandom));
                    send_word(cmd, idle_pct);
                end
                if ($urandom_range(0, 4) != 0)
                begin
                    cmd.char_code = NEWLINE_CODE;
                    send_word(cmd, idle_pct);
                end
            end
            else if (pick < 85)
            begin
                repeat ($urandom_range(1, 4))
                begin
                    cmd.action = ACT_READ;
                    if ($urandom_range(0, 2) == 0)
                    begin
                        cmd.cell_row = 5'($urandom);
                        cmd.cell_col = 7'($urandom);
                    end
                    else
                    begin
                        row = sb.cur_row - int'($urandom_range(0, 1));
                        if (row < 0)
                        begin
                            row = 0;
                        end
                        cmd.cell_row = 5'(row);
                        cmd.cell_col = 7'($urandom_range(0, COLUMNS_DEFAULT - 1));
                    end
                    send_word(cmd, idle_pct);
                end
            end
            else if (pick < 88)
            begin
                cmd.action = ACT_CLEAR;
                send_word(cmd, idle_pct);
            end
            else if (pick < 92)
            begin
                cmd.action = ACT_UNUSED;
                send_word(cmd, idle_pct);
            end
            else
            begin
                send_word(cmd, idle_pct);
            end
            if ($urandom_range(0, 39) == 0)
            begin
                drain();
            end
        end
    endtask

    initial
    begin
        sb = new;
        sb.power_on();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        send_word(make_word(ACT_READ, 8'h00, 5'd0, 7'd0), 19);
        send_word(make_word(ACT_READ, 8'hFF, 5'd24, 7'd79), 19);
        send_word(make_word(ACT_READ, 8'h00, 5'd25, 7'd0), 19);
        send_word(make_word(ACT_READ, 8'h00, 5'd0, 7'd80), 19);
        send_word(make_word(ACT_READ, 8'hFF, 5'd31, 7'd127), 19);
        send_word(make_word(ACT_PUT, 8'h41, 5'd31, 7'd127), 19);
        send_word(make_word(ACT_PUT, 8'h00, 5'd0, 7'd0), 19);
        send_word(make_word(ACT_PUT, 8'hFF, 5'd0, 7'd0), 19);
        send_word(make_word(ACT_READ, 8'h00, 5'd0, 7'd0), 19);
        send_word(make_word(ACT_READ, 8'h00, 5'd0, 7'd2), 19);
        send_word(make_word(ACT_PUT, NEWLINE_CODE, 5'd31, 7'd127), 19);
        send_word(make_word(ACT_UNUSED, 8'hFF, 5'd31, 7'd127), 19);
        send_word(make_word(ACT_PUT, SPACE_CODE, 5'd0, 7'd0), 19);
        send_word(make_word(ACT_READ, 8'h00, 5'd1, 7'd0), 19);
        send_word(make_word(ACT_CLEAR, 8'hFF, 5'd31, 7'd127), 19);
        send_word(make_word(ACT_READ, 8'h00, 5'd0, 7'd0), 19);
        send_word(make_word(ACT_READ, 8'h00, 5'd1, 7'd1), 19);

        drain();
        write_color(8'h00);
        random_phase(210, 19);
        drain();
        write_color(8'hFF);
        random_phase(210, 61);
        drain();
        write_color(8'($urandom_range(1, 254)));
        random_phase(210, 0);
        drain();
        repeat (10) @(posedge clk);

        while (sb.pending.size() != 0)
        begin
            sb.report($sformatf("result word %h never arrived", sb.pending.pop_front()));
        end
        if (sb.fails == 0)
        begin
            $display("tb_text_console_writer_top passed");
        end
        else
        begin
            $display("tb_text_console_writer_top failed");
        end
        $finish;
    end

endmodule
